[rtl/sst_pkg.sv]
package sst_pkg;

  // fixed field widths
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DATA_W = 32;

  // default number of leaf positions
  localparam int unsigned LEAVES_DEFAULT = 1024;

  // operation codes
  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

[rtl/sum_segment_tree_core.sv]
// Range-sum segment tree over LEAVES positions, 32-bit wrapping sums. The
// whole tree sits in one on-chip memory of 2*LEAVES words: two read ports,
// one write port, registered read data. An update transfer (operation =
// set) writes one leaf and then recomputes one ancestor per cycle: one
// adder adds the freshly written child to its sibling, read the cycle
// before. It gives no result; a position of LEAVES or more is dropped. A
// query transfer walks the tree bottom up one level per cycle, reading the
// left and right boundary nodes on the two read ports and folding them
// into one accumulator, then passes the sum through the ST_FIN state into
// the result register once that register is free; an empty range skips
// the walk and returns 0 the same way. One item is worked at a time;
// in_stall_o is high until the item is finished. A finished result waits
// in its output register, so the next item is taken while it is still
// stalled. After reset the block clears all 2*LEAVES words of the memory,
// one word a cycle, before it takes the first item.
module sum_segment_tree_core #(
  parameter int unsigned LEAVES = sst_pkg::LEAVES_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input items
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic [sst_pkg::IDX_W-1:0]            first_index_i,
  input  logic [sst_pkg::IDX_W-1:0]            last_index_i,
  input  logic signed [sst_pkg::DATA_W-1:0]    write_value_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [sst_pkg::DATA_W-1:0]    range_sum_o
);

  // node address width: nodes 1 .. 2*LEAVES-1
  localparam int unsigned NW    = $clog2(2 * LEAVES);
  localparam int unsigned DEPTH = 2 * LEAVES;
  // compare width wide enough for both the input index and a node number
  localparam int unsigned CW    = (sst_pkg::IDX_W > NW) ? sst_pkg::IDX_W : NW;
  localparam int unsigned DW    = sst_pkg::DATA_W;

  // sequencer states
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_QRY  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [NW-1:0] clr_cnt_q, clr_cnt_d;
  logic [NW-1:0] cur_q, cur_d;         // update walk: node written this cycle
  logic [NW-1:0] lo_q, lo_d;           // query walk: left boundary
  logic [NW-1:0] hi_q, hi_d;           // query walk: right boundary
  logic          take_a_q, take_a_d;   // port a read data belongs in the sum
  logic          take_b_q, take_b_d;   // port b read data belongs in the sum
  logic [DW-1:0] acc_q, acc_d;
  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] res_q, res_d;

  // tree memory
  logic [DW-1:0] tree_mem [DEPTH];
  logic [DW-1:0] rd_a_q, rd_b_q;
  logic [NW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic [DW-1:0] wr_data;
  logic          wr_en;

  // decode of the incoming item
  logic          in_xfer;
  logic [CW-1:0] first_cw, last_cw, leaves_cw, hi_clamp;
  logic          pos_ok, range_empty;
  logic [NW-1:0] leaf_node;
  logic [DW-1:0] upd_sum, qry_sum, term_a, term_b;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign first_cw    = CW'(first_index_i);
  assign last_cw     = CW'(last_index_i);
  assign leaves_cw   = CW'(LEAVES);
  // query range end saturates at the last leaf
  assign hi_clamp    = (last_cw >= leaves_cw) ? (leaves_cw - CW'(1)) : last_cw;
  assign pos_ok      = (first_cw < leaves_cw);
  assign range_empty = (first_cw > hi_clamp);
  assign leaf_node   = NW'(LEAVES) + first_cw[NW-1:0];

  // the one adder of the update walk: new child plus its sibling
  assign upd_sum = acc_q + rd_a_q;

  // query fold of the boundary nodes read the cycle before
  assign term_a  = take_a_q ? rd_a_q : '0;
  assign term_b  = take_b_q ? rd_b_q : '0;
  assign qry_sum = acc_q + term_a + term_b;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cur_d       = cur_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    take_a_d    = 1'b0;
    take_b_d    = 1'b0;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    rd_a_addr   = lo_q;
    rd_b_addr   = hi_q;
    wr_addr     = cur_q;
    wr_data     = upd_sum;
    wr_en       = 1'b0;

    // result leaves on its transfer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLR: begin
        // post-reset sweep, one word per cycle
        wr_en     = 1'b1;
        wr_addr   = clr_cnt_q;
        wr_data   = '0;
        clr_cnt_d = clr_cnt_q + NW'(1);
        if (clr_cnt_q == NW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          if (operation_i == sst_pkg::OP_SET) begin
            if (pos_ok) begin
              // write the leaf, fetch its sibling, climb to the parent
              wr_en     = 1'b1;
              wr_addr   = leaf_node;
              wr_data   = $unsigned(write_value_i);
              rd_a_addr = leaf_node ^ NW'(1);
              acc_d     = $unsigned(write_value_i);
              cur_d     = leaf_node >> 1;
              state_d   = ST_UPD;
            end
          end else begin
            acc_d = '0;
            if (range_empty) begin
              state_d = ST_FIN;
            end else begin
              lo_d    = leaf_node;
              hi_d    = NW'(LEAVES) + hi_clamp[NW-1:0];
              state_d = ST_QRY;
            end
          end
        end
      end

      ST_UPD: begin
        wr_en     = 1'b1;
        wr_addr   = cur_q;
        wr_data   = upd_sum;
        rd_a_addr = cur_q ^ NW'(1);
        acc_d     = upd_sum;
        cur_d     = cur_q >> 1;
        if (cur_q == NW'(1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_QRY: begin
        acc_d = qry_sum;
        if (lo_q <= hi_q) begin
          // odd left boundary and even right boundary are taken whole
          rd_a_addr = lo_q;
          rd_b_addr = hi_q;
          take_a_d  = lo_q[0];
          take_b_d  = !hi_q[0];
          lo_d      = (lo_q >> 1) + NW'(lo_q[0]);
          hi_d      = (hi_q >> 1) - NW'(!hi_q[0]);
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        // wait for a free result register
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          res_d       = acc_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      take_a_q    <= 1'b0;
      take_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      take_a_q    <= take_a_d;
      take_b_q    <= take_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  // tree memory, registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tree_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= tree_mem[rd_a_addr];
    rd_b_q <= tree_mem[rd_b_addr];
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = $signed(res_q);

  // no result shows up while the memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !out_valid_o)
    else $error("result during clearing sweep");

  // an update transfer never raises a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && operation_i == sst_pkg::OP_SET) |=> !$rose(out_valid_o))
    else $error("update produced a result");

  // the update walk never reaches node zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (cur_q != '0))
    else $error("update walk past the root");

  // the left boundary of a query walk stays a real node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QRY) |-> (lo_q != '0))
    else $error("query walk left boundary at node zero");

endmodule

[verif/sum_segment_tree_core_tb.sv]
`timescale 1ns / 100ps

module sum_segment_tree_core_tb;

  localparam int unsigned NUM_LEAVES  = sst_pkg::LEAVES_DEFAULT;
  localparam int unsigned IDX_MAX     = (1 << sst_pkg::IDX_W) - 1;
  // cycles with no transfer on either side before the run is called hung;
  // covers the memory clear after reset and the long receiver hold-off
  localparam int unsigned STALL_LIMIT = 10000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef logic [sst_pkg::IDX_W-1:0]         idx_t;
  typedef logic signed [sst_pkg::DATA_W-1:0] word_t;

  // shadow copy of the tree plus the sums still owed by the block
  class range_sum_tracker;
    logic [sst_pkg::DATA_W-1:0] nodes [2*NUM_LEAVES];
    word_t                      owed_sums[$];
    int                         errors;

    function new();
      foreach (nodes[k]) nodes[k] = '0;
      errors = 0;
    endfunction

    function void write_leaf(int unsigned pos, logic [sst_pkg::DATA_W-1:0] value);
      int unsigned node;
      if (pos >= NUM_LEAVES) return;
      node = pos + NUM_LEAVES;
      nodes[node] = value;
      node = node >> 1;
      while (node >= 1) begin
        nodes[node] = nodes[2*node] + nodes[2*node+1];
        node = node >> 1;
      end
    endfunction

    function logic [sst_pkg::DATA_W-1:0] sum_over(int unsigned lo, int unsigned hi);
      logic [sst_pkg::DATA_W-1:0] acc;
      acc = '0;
      if (hi >= NUM_LEAVES) hi = NUM_LEAVES - 1;
      if (lo > hi) return '0;
      lo = lo + NUM_LEAVES;
      hi = hi + NUM_LEAVES;
      while (lo <= hi) begin
        if (lo[0]) begin
          acc = acc + nodes[lo];
          lo  = lo + 1;
        end
        if (!hi[0]) begin
          acc = acc + nodes[hi];
          hi  = hi - 1;
        end
        lo = lo >> 1;
        hi = hi >> 1;
      end
      return acc;
    endfunction

    function void note_transfer(logic op, idx_t first, idx_t last, word_t value);
      if (op == sst_pkg::OP_SET) write_leaf(first, value);
      else owed_sums = {owed_sums, word_t'(sum_over(first, last))};
    endfunction

    function void check_sum(word_t actual);
      word_t want;
      if (owed_sums.size() == 0) begin
        $error("range_sum: unexpected result %0d", actual);
        errors++;
        return;
      end
      want = owed_sums.pop_front();
      if (actual !== want) begin
        $error("range_sum: expected %0d, got %0d", want, actual);
        errors++;
      end
    endfunction

    function int owed();
      return owed_sums.size();
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  logic  operation_i;
  idx_t  first_index_i;
  idx_t  last_index_i;
  word_t write_value_i;
  logic  out_valid_o;
  logic  out_stall_i;
  word_t range_sum_o;

  range_sum_tracker tracker;

  // idling percentages for the current phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;
  int unsigned quiet_cycles;

  sum_segment_tree_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .first_index_i (first_index_i),
    .last_index_i  (last_index_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .range_sum_o   (range_sum_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // transfer monitor: feeds the tracker and counts quiet cycles
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      if (in_valid_i && in_stall_o === 1'b0)
        tracker.note_transfer(operation_i, first_index_i, last_index_i, write_value_i);
      if (out_valid_o === 1'b1 && !out_stall_i)
        tracker.check_sum(range_sum_o);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("** sum_segment_tree_core: FAILED **");
    $finish;
  end

  // receiver: random stall per phase, or one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left = hold_left - 1;
      end else if (hold_request) begin
        out_stall_i <= 1'b1;
        hold_left    = HOLD_CYCLES - 1;
        hold_request = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one item; called and returns at a falling edge
  task automatic send_item(logic op, idx_t first, idx_t last, word_t value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    first_index_i <= first;
    last_index_i  <= last;
    write_value_i <= value;
    // wait for the transfer
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return -32'sd1;
      3:       return word_t'($urandom_range(15));
      default: return word_t'($urandom);
    endcase
  endfunction

  // random item: set or query with a mix of range shapes
  task automatic send_random(int unsigned query_pct);
    logic  op;
    idx_t  first;
    idx_t  last;
    word_t value;
    op    = ($urandom_range(99) < query_pct) ? sst_pkg::OP_QUERY : sst_pkg::OP_SET;
    value = pick_value();
    first = idx_t'($urandom_range(IDX_MAX));
    last  = idx_t'($urandom_range(IDX_MAX));
    case ($urandom_range(4))
      0: last = first + idx_t'($urandom_range(7));  // narrow range, may wrap to empty
      1: if (first < last) begin  // swapped bounds give an empty range
        first ^= last;
        last  ^= first;
        first ^= last;
      end
      2: first = '0;
      3: last = idx_t'(IDX_MAX);
      default: ;
    endcase
    send_item(op, first, last, value);
  endtask

  initial begin
    tracker        = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = sst_pkg::OP_SET;
    first_index_i  = '0;
    last_index_i   = '0;
    write_value_i  = '0;
    out_stall_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    quiet_cycles   = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part: cleared tree, extreme leaves and values, wrap, empty ranges
    send_item(sst_pkg::OP_QUERY, '0, idx_t'(IDX_MAX), 32'sh5a5a5a5a);
    send_item(sst_pkg::OP_SET, '0, idx_t'(IDX_MAX), 32'sh7fffffff);
    send_item(sst_pkg::OP_SET, idx_t'(IDX_MAX), '0, 32'sh80000000);
    send_item(sst_pkg::OP_SET, 10'd511, 10'd3, -32'sd1);
    send_item(sst_pkg::OP_SET, 10'd512, 10'd0, 32'sd1);
    send_item(sst_pkg::OP_QUERY, '0, idx_t'(IDX_MAX), '0);
    send_item(sst_pkg::OP_QUERY, '0, '0, '1);
    send_item(sst_pkg::OP_QUERY, idx_t'(IDX_MAX), idx_t'(IDX_MAX), '0);
    send_item(sst_pkg::OP_QUERY, 10'd511, 10'd512, '0);
    send_item(sst_pkg::OP_QUERY, 10'd5, 10'd3, '0);
    send_item(sst_pkg::OP_QUERY, idx_t'(IDX_MAX), '0, '0);
    send_item(sst_pkg::OP_SET, 10'd1, '1, 32'sh7fffffff);
    send_item(sst_pkg::OP_QUERY, '0, 10'd1, '0);  // positive overflow wraps
    send_item(sst_pkg::OP_SET, 10'd1, '0, 32'sh12345678);
    send_item(sst_pkg::OP_SET, 10'd1, '0, -32'sd7);  // overwrite the same leaf
    send_item(sst_pkg::OP_QUERY, 10'd1, 10'd1, '0);
    send_item(sst_pkg::OP_QUERY, 10'd1, 10'd1022, '0);
    send_item(sst_pkg::OP_QUERY, 10'd512, idx_t'(IDX_MAX), '0);
    send_item(sst_pkg::OP_SET, 10'd682, 10'd341, 32'shaaaaaaaa);
    send_item(sst_pkg::OP_QUERY, 10'd341, 10'd682, 32'sh55555555);
    send_item(sst_pkg::OP_QUERY, 10'd682, 10'd682, '0);

    // no idling, then the long receiver hold-off while queries keep coming
    repeat (150) send_random(60);
    hold_request = 1'b1;
    repeat (30) send_random(90);

    send_idle_pct  = 83;
    recv_stall_pct = 0;
    repeat (150) send_random(60);

    send_idle_pct  = 0;
    recv_stall_pct = 83;
    repeat (150) send_random(60);

    send_idle_pct  = 26;
    recv_stall_pct = 26;
    repeat (170) send_random(60);

    in_valid_i <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (tracker.errors == 0 && tracker.owed() == 0) begin
      $display("** sum_segment_tree_core: PASSED **");
    end else begin
      $display("** sum_segment_tree_core: FAILED **");
    end
    $finish;
  end

endmodule
